@@ src/sahu_pkg.sv @@
`default_nettype none

package sahu_pkg;

    localparam int TABLE_SLOTS_DEF = 512;

    localparam int SLOT_W     = 9;
    localparam int TIME_W     = 32;
    localparam int DELAY_W    = 16;
    localparam int USE_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [SLOT_W-1:0]  FIRST_SLOT_RST   = SLOT_W'(33);
    localparam logic [DELAY_W-1:0] EARLY_WINDOW_RST = DELAY_W'(2000);
    localparam logic [DELAY_W-1:0] REUSE_DELAY_RST  = DELAY_W'(500);

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SLOT   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_EARLY_WINDOW = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_REUSE_DELAY  = CFG_IDX_W'(2);

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] now;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0] granted_slot;
        logic              grew;
        logic              overflow;
    } rsp_t;

    typedef struct packed {
        logic              free;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SEEK,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

@@ src/sahu_cell.sv @@
`default_nettype none

module sahu_cell (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             shift,
    input  wire logic             load,
    input  wire sahu_pkg::entry_t shift_in,
    input  wire sahu_pkg::entry_t load_in,
    output sahu_pkg::entry_t      q
);

    logic                        free_reg;
    logic [sahu_pkg::TIME_W-1:0] stamp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= 1'b0;
        end
        else if (shift)
        begin
            free_reg <= shift_in.free;
        end
        else if (load)
        begin
            free_reg <= load_in.free;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            stamp_reg <= shift_in.stamp;
        end
        else if (load)
        begin
            stamp_reg <= load_in.stamp;
        end
    end

    assign q.free  = free_reg;
    assign q.stamp = stamp_reg;

endmodule

`default_nettype wire

@@ src/slot_allocator_reuse_holdoff_unit.sv @@
`default_nettype none

// channel | valid     | stall     | word      | moves
// --------+-----------+-----------+-----------+----------------------------
// request | req_valid | req_stall | req       | mode, slot, now
// result  | rsp_valid | rsp_stall | rsp       | granted_slot, grew, overflow
// config  | cfg_we    | -         | cfg_data  | cfg_index selects register
//
// Slot entries live in a ring of TABLE_SLOTS cells that rotates one cell a cycle
// while a request scans or seeks. Free: rotate an in-table slot to the head cell
// and mark it free with the request time. Allocate: one full revolution to scan,
// then rotation to the chosen slot, which is then marked not free.
// Reset marks every slot not free at once; no sweep follows.
// One word in flight; rsp_stall holds the finished word in the output register.

module slot_allocator_reuse_holdoff_unit #(
    parameter int TABLE_SLOTS = sahu_pkg::TABLE_SLOTS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             req_valid,
    output logic                                  req_stall,
    input  wire sahu_pkg::req_t                   req,
    output logic                                  rsp_valid,
    input  wire logic                             rsp_stall,
    output sahu_pkg::rsp_t                        rsp,
    input  wire logic                             cfg_we,
    input  wire logic [sahu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [sahu_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int IW   = $clog2(TABLE_SLOTS);
    localparam int CMPW = (IW > sahu_pkg::USE_W) ? IW : sahu_pkg::USE_W;
    localparam logic [CMPW:0]   N_C  = (CMPW+1)'(TABLE_SLOTS);
    localparam logic [IW-1:0]   LAST = IW'(TABLE_SLOTS - 1);

    sahu_pkg::state_t state_reg, state_next;
    sahu_pkg::req_t   req_reg, req_next;
    sahu_pkg::rsp_t   rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;

    logic [IW-1:0]    ptr_reg, ptr_next;
    logic [IW-1:0]    count_reg, count_next;
    logic [IW-1:0]    best_reg, best_next;
    logic [IW-1:0]    target_reg, target_next;
    logic             found_reg, found_next;
    logic             grew_reg, grew_next;
    logic             ov_reg, ov_next;

    logic [sahu_pkg::USE_W-1:0]   siu_reg, siu_next;
    logic [sahu_pkg::SLOT_W-1:0]  first_slot_reg, first_slot_next;
    logic [sahu_pkg::DELAY_W-1:0] early_reg, early_next;
    logic [sahu_pkg::DELAY_W-1:0] delay_reg, delay_next;

    sahu_pkg::entry_t ring_q [TABLE_SLOTS];
    sahu_pkg::entry_t head;
    sahu_pkg::entry_t head_wd;
    logic             rotate;
    logic             head_wr;

    logic [CMPW-1:0]              head_idx;
    logic                         in_range;
    logic [sahu_pkg::TIME_W-1:0]  age;
    logic                         eligible;
    logic                         better;
    logic [IW-1:0]                ptr_inc;
    logic [sahu_pkg::USE_W-1:0]   cand;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_SLOTS; gi++)
        begin : g_ring
            if (gi == 0)
            begin : g_head
                sahu_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift    (rotate),
                    .load     (head_wr),
                    .shift_in (ring_q[(gi + 1) % TABLE_SLOTS]),
                    .load_in  (head_wd),
                    .q        (ring_q[gi])
                );
            end
            else
            begin : g_body
                sahu_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift    (rotate),
                    .load     (1'b0),
                    .shift_in (ring_q[(gi + 1) % TABLE_SLOTS]),
                    .load_in  (head_wd),
                    .q        (ring_q[gi])
                );
            end
        end
    endgenerate

    assign head = ring_q[0];

    assign head_idx = CMPW'(ptr_reg);
    assign in_range = (head_idx >= CMPW'(first_slot_reg)) && (head_idx < CMPW'(siu_reg));
    assign age      = req_reg.now - head.stamp;
    assign eligible = head.free && in_range &&
                      ((head.stamp < sahu_pkg::TIME_W'(early_reg)) ||
                       ((req_reg.now >= head.stamp) && (age > sahu_pkg::TIME_W'(delay_reg))));
    assign better   = eligible && (!found_reg || (ptr_reg < best_reg));
    assign ptr_inc  = (ptr_reg == LAST) ? '0 : ptr_reg + IW'(1);
    assign cand     = (siu_reg > sahu_pkg::USE_W'(first_slot_reg)) ?
                      siu_reg : sahu_pkg::USE_W'(first_slot_reg);

    assign req_stall = (state_reg != sahu_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg;
        ptr_next        = ptr_reg;
        count_next      = count_reg;
        best_next       = best_reg;
        target_next     = target_reg;
        found_next      = found_reg;
        grew_next       = grew_reg;
        ov_next         = ov_reg;
        siu_next        = siu_reg;
        first_slot_next = first_slot_reg;
        early_next      = early_reg;
        delay_next      = delay_reg;
        rotate          = 1'b0;
        head_wr         = 1'b0;
        head_wd         = head;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            sahu_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    grew_next  = 1'b0;
                    ov_next    = 1'b0;
                    count_next = '0;
                    found_next = 1'b0;
                    if (req.mode == sahu_pkg::MODE_FREE)
                    begin
                        target_next = IW'(req.slot);
                        if ((CMPW+1)'(req.slot) < N_C)
                        begin
                            state_next = sahu_pkg::ST_SEEK;
                        end
                        else
                        begin
                            state_next = sahu_pkg::ST_RESULT;
                        end
                    end
                    else
                    begin
                        state_next = sahu_pkg::ST_SCAN;
                    end
                end
            end

            sahu_pkg::ST_SCAN:
            begin
                rotate     = 1'b1;
                ptr_next   = ptr_inc;
                count_next = count_reg + IW'(1);
                if (better)
                begin
                    best_next  = ptr_reg;
                    found_next = 1'b1;
                end
                if (count_reg == LAST)
                begin
                    state_next = sahu_pkg::ST_SEEK;
                    if (found_next)
                    begin
                        target_next = best_next;
                    end
                    else if ((CMPW+1)'(cand) >= N_C)
                    begin
                        target_next = LAST;
                        ov_next     = 1'b1;
                    end
                    else
                    begin
                        target_next = IW'(cand);
                        grew_next   = 1'b1;
                        siu_next    = cand + sahu_pkg::USE_W'(1);
                    end
                end
            end

            sahu_pkg::ST_SEEK:
            begin
                if (ptr_reg == target_reg)
                begin
                    head_wr = 1'b1;
                    if (req_reg.mode == sahu_pkg::MODE_FREE)
                    begin
                        head_wd.free  = 1'b1;
                        head_wd.stamp = req_reg.now;
                    end
                    else
                    begin
                        head_wd.free = 1'b0;
                    end
                    state_next = sahu_pkg::ST_RESULT;
                end
                else
                begin
                    rotate   = 1'b1;
                    ptr_next = ptr_inc;
                end
            end

            sahu_pkg::ST_RESULT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.grew         = grew_reg;
                    rsp_next.overflow     = ov_reg;
                    rsp_next.granted_slot = (req_reg.mode == sahu_pkg::MODE_FREE) ?
                                            req_reg.slot : sahu_pkg::SLOT_W'(target_reg);
                    state_next            = sahu_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = sahu_pkg::ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            unique case (cfg_index)
                sahu_pkg::CFG_FIRST_SLOT:   first_slot_next = cfg_data[sahu_pkg::SLOT_W-1:0];
                sahu_pkg::CFG_EARLY_WINDOW: early_next      = cfg_data;
                sahu_pkg::CFG_REUSE_DELAY:  delay_next      = cfg_data;
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sahu_pkg::ST_IDLE;
            rsp_valid_reg  <= 1'b0;
            ptr_reg        <= '0;
            count_reg      <= '0;
            found_reg      <= 1'b0;
            grew_reg       <= 1'b0;
            ov_reg         <= 1'b0;
            siu_reg        <= sahu_pkg::USE_W'(sahu_pkg::FIRST_SLOT_RST);
            first_slot_reg <= sahu_pkg::FIRST_SLOT_RST;
            early_reg      <= sahu_pkg::EARLY_WINDOW_RST;
            delay_reg      <= sahu_pkg::REUSE_DELAY_RST;
        end
        else
        begin
            state_reg      <= state_next;
            rsp_valid_reg  <= rsp_valid_next;
            ptr_reg        <= ptr_next;
            count_reg      <= count_next;
            found_reg      <= found_next;
            grew_reg       <= grew_next;
            ov_reg         <= ov_next;
            siu_reg        <= siu_next;
            first_slot_reg <= first_slot_next;
            early_reg      <= early_next;
            delay_reg      <= delay_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        rsp_reg    <= rsp_next;
        best_reg   <= best_next;
        target_reg <= target_next;
    end

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted while another is in flight");

    a_free_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sahu_pkg::ST_RESULT && req_reg.mode == sahu_pkg::MODE_FREE)
        |-> (!grew_reg && !ov_reg))
        else $error("free result carries grow or overflow flag");

    a_overflow_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sahu_pkg::ST_SEEK && ov_reg) |-> (target_reg == LAST && !grew_reg))
        else $error("overflow claim not aimed at the last slot");

endmodule

`default_nettype wire

@@ tb/tb_slot_allocator_reuse_holdoff_unit.sv @@
`timescale 1ns / 100ps

module tb_slot_allocator_reuse_holdoff_unit;
    import sahu_pkg::*;

    localparam int SLOTS = TABLE_SLOTS_DEF;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 144;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_TYPED,
        ROW_CFG
    } row_kind_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_BURST
    } stall_style_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_sel;
        logic [CFG_DATA_W-1:0] value;
        req_t                  word;
        rsp_t                  want;
    } row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_stall;
    req_t                  req;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_t                  rsp;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // allocator mirror
    bit                    slot_free_now [SLOTS];
    logic [TIME_W-1:0]     freed_stamp [SLOTS];
    logic [USE_W-1:0]      slots_grown;
    logic [SLOT_W-1:0]     lowest_slot;
    logic [DELAY_W-1:0]    early_ticks;
    logic [DELAY_W-1:0]    holdoff_ticks;

    rsp_t                  grants_due [$];
    row_t                  script [$];
    logic [SLOT_W-1:0]     live_slots [$];
    logic [SLOT_W-1:0]     freed_slots [$];
    logic [TIME_W-1:0]     tick;
    int unsigned           burst_left = 0;
    int unsigned           bad_words = 0;
    int unsigned           stall_count = 0;
    stall_style_t          stall_style = STALL_NONE;

    slot_allocator_reuse_holdoff_unit #(
        .TABLE_SLOTS(SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit reusable_at(input int unsigned idx, input logic [TIME_W-1:0] at);
        logic [TIME_W-1:0] stamp;
        stamp = freed_stamp[idx];
        if (!slot_free_now[idx])
            return 1'b0;
        if (stamp < {16'd0, early_ticks})
            return 1'b1;
        return (at >= stamp) && ((at - stamp) > {16'd0, holdoff_ticks});
    endfunction

    function automatic rsp_t predict_grant(input req_t w);
        rsp_t        r;
        int unsigned limit;
        int unsigned cand;
        bit          hit;
        r = '0;
        hit = 1'b0;
        if (w.mode == MODE_FREE)
        begin
            if (int'(w.slot) < SLOTS)
            begin
                slot_free_now[w.slot] = 1'b1;
                freed_stamp[w.slot] = w.now;
            end
            r.granted_slot = w.slot;
        end
        else
        begin
            limit = (slots_grown > SLOTS) ? SLOTS : slots_grown;
            for (int unsigned i = lowest_slot; i < limit; i++)
            begin
                if (reusable_at(i, w.now))
                begin
                    r.granted_slot = SLOT_W'(i);
                    hit = 1'b1;
                    break;
                end
            end
            if (!hit)
            begin
                cand = (slots_grown > lowest_slot) ? slots_grown : lowest_slot;
                if (cand >= SLOTS)
                begin
                    r.granted_slot = SLOT_W'(SLOTS - 1);
                    r.overflow = 1'b1;
                end
                else
                begin
                    r.granted_slot = SLOT_W'(cand);
                    slots_grown = USE_W'(cand + 1);
                    r.grew = 1'b1;
                end
            end
            slot_free_now[r.granted_slot] = 1'b0;
        end
        return r;
    endfunction

    function automatic row_t step_row(input row_kind_t kind, input logic mode,
                                      input logic [SLOT_W-1:0] slot,
                                      input logic [TIME_W-1:0] now, input rsp_t want);
        row_t r;
        r = '0;
        r.kind = kind;
        r.word.mode = mode;
        r.word.slot = slot;
        r.word.now = now;
        r.want = want;
        return r;
    endfunction

    function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] sel,
                                     input logic [CFG_DATA_W-1:0] value);
        row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.reg_sel = sel;
        r.value = value;
        return r;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input req_t w, input bit typed, input rsp_t want,
                             output rsp_t predicted);
        int unsigned gap;
        cfg_we <= 1'b0;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        req <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = predict_grant(w);
        grants_due.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel,
                             input logic [CFG_DATA_W-1:0] value);
        req_valid <= 1'b0;
        burst_left = 0;
        while (grants_due.size() != 0)
            @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_data <= value;
        case (sel)
            CFG_FIRST_SLOT:   lowest_slot = value[SLOT_W-1:0];
            CFG_EARLY_WINDOW: early_ticks = value;
            CFG_REUSE_DELAY:  holdoff_ticks = value;
            default:          ;
        endcase
        @(negedge clk);
    endtask

    task automatic random_phase(input int unsigned phase_no, input int unsigned count);
        req_t                  w;
        rsp_t                  got;
        logic [CFG_DATA_W-1:0] data;
        int unsigned           first;
        int unsigned           pick;
        int unsigned           k;
        if (phase_no == 0)
            first = 0;
        else if (phase_no == PHASES - 2)
            first = 500;
        else if (phase_no == PHASES - 1)
            first = SLOTS - 1;
        else if ($urandom_range(0, 2) == 0)
            first = slots_grown + $urandom_range(0, 6);
        else
            first = $urandom_range(0, 60);
        if (first > SLOTS - 1)
            first = SLOTS - 1;
        data = CFG_DATA_W'($urandom);
        data[SLOT_W-1:0] = SLOT_W'(first);
        write_reg(CFG_FIRST_SLOT, data);
        case ($urandom_range(0, 3))
            0:       data = '0;
            1:       data = '1;
            2:       data = CFG_DATA_W'($urandom_range(0, 4000));
            default: data = CFG_DATA_W'($urandom);
        endcase
        write_reg(CFG_EARLY_WINDOW, data);
        case ($urandom_range(0, 3))
            0:       data = '0;
            1:       data = '1;
            default: data = CFG_DATA_W'($urandom_range(0, 1500));
        endcase
        write_reg(CFG_REUSE_DELAY, data);
        if ($urandom_range(0, 1) == 0)
            tick = $urandom_range(0, 70000);

        for (int unsigned n = 0; n < count; n++)
        begin
            w.slot = SLOT_W'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 50)
                w.mode = MODE_ALLOC;
            else
            begin
                w.mode = MODE_FREE;
                if (pick < 80 && live_slots.size() != 0)
                begin
                    k = $urandom_range(0, live_slots.size() - 1);
                    w.slot = live_slots[k];
                    live_slots.delete(k);
                end
                else if (pick < 88 && freed_slots.size() != 0)
                    w.slot = freed_slots[$urandom_range(0, freed_slots.size() - 1)];
            end
            pick = $urandom_range(0, 99);
            if (pick < 4)
                w.now = $urandom;
            else if (pick < 10)
                w.now = tick - $urandom_range(0, 1000);
            else
            begin
                tick = tick + $urandom_range(0, 700);
                w.now = tick;
            end
            send_word(w, 1'b0, '0, got);
            if (w.mode == MODE_ALLOC)
                live_slots.push_back(got.granted_slot);
            else
            begin
                freed_slots.push_back(w.slot);
                if (freed_slots.size() > 16)
                    void'(freed_slots.pop_front());
            end
        end
    endtask

    always @(negedge clk)
    begin
        stall_count <= stall_count + 1;
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (stall_count % 256 == 0)
                stall_style <= stall_style_t'($urandom_range(0, 2));
            case (stall_style)
                STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
                STALL_BURST:  rsp_stall <= (stall_count % 5) < 2;
                default:      rsp_stall <= 1'b0;
            endcase
        end
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (grants_due.size() == 0)
            begin
                if (bad_words < 10)
                    $display("unexpected result word: slot %0d grew %0d overflow %0d",
                             rsp.granted_slot, rsp.grew, rsp.overflow);
                bad_words++;
            end
            else
            begin
                want = grants_due.pop_front();
                if (rsp.granted_slot !== want.granted_slot || rsp.grew !== want.grew
                    || rsp.overflow !== want.overflow)
                begin
                    if (bad_words < 10)
                        $display("result mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                 want.granted_slot, want.grew, want.overflow,
                                 rsp.granted_slot, rsp.grew, rsp.overflow);
                    bad_words++;
                end
            end
        end
    end

    initial
    begin
        #100_000_000;
        $display("[slot_allocator_reuse_holdoff_unit] ERROR");
        $finish;
    end

    initial
    begin
        rsp_t got;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        lowest_slot = FIRST_SLOT_RST;
        early_ticks = EARLY_WINDOW_RST;
        holdoff_ticks = REUSE_DELAY_RST;
        slots_grown = USE_W'(FIRST_SLOT_RST);
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_free_now[i] = 1'b0;
            freed_stamp[i] = '0;
        end
        tick = 32'd20000;

        // reset values: first slot 33, early window 2000, reuse delay 500
        script.push_back(step_row(ROW_TYPED, MODE_ALLOC, 9'd0, 32'd0, {9'd33, 1'b1, 1'b0}));
        script.push_back(step_row(ROW_TYPED, MODE_ALLOC, 9'h1FF, 32'hFFFF_FFFF,
                                  {9'd34, 1'b1, 1'b0}));
        script.push_back(step_row(ROW_TYPED, MODE_FREE, 9'd33, 32'd100, {9'd33, 1'b0, 1'b0}));
        // freed inside the early window: reused at once
        script.push_back(step_row(ROW_TYPED, MODE_ALLOC, 9'd0, 32'd100, {9'd33, 1'b0, 1'b0}));
        script.push_back(step_row(ROW_TYPED, MODE_FREE, 9'd34, 32'd5000, {9'd34, 1'b0, 1'b0}));
        script.push_back(step_row(ROW_TYPED, MODE_ALLOC, 9'd0, 32'd5300, {9'd35, 1'b1, 1'b0}));
        // exactly the delay is not enough, one tick more is
        script.push_back(step_row(ROW_TYPED, MODE_ALLOC, 9'd0, 32'd5500, {9'd36, 1'b1, 1'b0}));
        script.push_back(step_row(ROW_TYPED, MODE_ALLOC, 9'd0, 32'd5501, {9'd34, 1'b0, 1'b0}));
        script.push_back(step_row(ROW_TYPED, MODE_FREE, 9'd35, 32'd9000, {9'd35, 1'b0, 1'b0}));
        // time going backwards
        script.push_back(step_row(ROW_TYPED, MODE_ALLOC, 9'd0, 32'd8000, {9'd37, 1'b1, 1'b0}));
        // free the last slot of the table and a slot below the first slot
        script.push_back(step_row(ROW_TYPED, MODE_FREE, 9'd511, 32'd1, {9'd511, 1'b0, 1'b0}));
        script.push_back(step_row(ROW_TYPED, MODE_FREE, 9'd0, 32'hFFFF_FFFF,
                                  {9'd0, 1'b0, 1'b0}));
        // double free restamps
        script.push_back(step_row(ROW_TYPED, MODE_FREE, 9'd35, 32'd10000, {9'd35, 1'b0, 1'b0}));
        script.push_back(step_row(ROW_TYPED, MODE_ALLOC, 9'd0, 32'd10400, {9'd38, 1'b1, 1'b0}));
        script.push_back(step_row(ROW_TYPED, MODE_ALLOC, 9'd0, 32'd10501, {9'd35, 1'b0, 1'b0}));
        script.push_back(cfg_row(CFG_EARLY_WINDOW, 16'hFFFF));
        script.push_back(cfg_row(CFG_REUSE_DELAY, 16'hFFFF));
        script.push_back(step_row(ROW_TYPED, MODE_FREE, 9'd36, 32'h0000_FFFE,
                                  {9'd36, 1'b0, 1'b0}));
        script.push_back(step_row(ROW_PREDICT, MODE_ALLOC, 9'h155, 32'd0, '0));
        script.push_back(cfg_row(CFG_EARLY_WINDOW, 16'h0000));
        script.push_back(cfg_row(CFG_REUSE_DELAY, 16'h0000));
        script.push_back(step_row(ROW_TYPED, MODE_FREE, 9'd37, 32'd0, {9'd37, 1'b0, 1'b0}));
        script.push_back(step_row(ROW_PREDICT, MODE_ALLOC, 9'h0AA, 32'd0, '0));
        script.push_back(step_row(ROW_PREDICT, MODE_ALLOC, 9'd0, 32'd1, '0));
        // upper data bits above the slot width are dropped
        script.push_back(cfg_row(CFG_FIRST_SLOT, 16'hFE00));
        script.push_back(step_row(ROW_PREDICT, MODE_ALLOC, 9'd0, 32'hFFFF_FFFF, '0));
        script.push_back(cfg_row(CFG_SPARE, 16'h1234));
        script.push_back(step_row(ROW_PREDICT, MODE_ALLOC, 9'd0, 32'h8000_0000, '0));

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[k])
        begin
            if (script[k].kind == ROW_CFG)
                write_reg(script[k].reg_sel, script[k].value);
            else
                send_word(script[k].word, script[k].kind == ROW_TYPED, script[k].want, got);
        end

        for (int p = 0; p < PHASES; p++)
            random_phase(p, PHASE_ITEMS);

        req_valid <= 1'b0;
        cfg_we <= 1'b0;
        while (grants_due.size() != 0)
            @(negedge clk);
        repeat (2 * SLOTS + 16) @(negedge clk);

        if (bad_words == 0)
            $display("[slot_allocator_reuse_holdoff_unit] OK");
        else
            $display("[slot_allocator_reuse_holdoff_unit] ERROR");
        $finish;
    end

endmodule

@@ slot_allocator_reuse_holdoff_unit.f @@
src/sahu_pkg.sv
src/sahu_cell.sv
src/slot_allocator_reuse_holdoff_unit.sv
tb/tb_slot_allocator_reuse_holdoff_unit.sv
